FILE: hdl/aes_block_cipher_defines.svh
// Assertion macros shared by the AES block cipher RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef AES_BLOCK_CIPHER_DEFINES_SVH
`define AES_BLOCK_CIPHER_DEFINES_SVH
`ifndef SYNTHESIS
`define AES_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define AES_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define AES_ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`define AES_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

FILE: hdl/aes_pkg.sv
// Shared types, S-box tables and round functions for the AES block cipher.
// No dependencies.
package aes_pkg;

    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;

    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_KSIZE = 3'd4;

    typedef struct packed {
        logic busy;
        logic done;
    } t_kx_status;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam logic [3:0] ROW_PERM [16] = '{
        4'd0, 4'd5, 4'd10, 4'd15, 4'd4, 4'd9, 4'd14, 4'd3,
        4'd8, 4'd13, 4'd2, 4'd7, 4'd12, 4'd1, 4'd6, 4'd11
    };

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] o;
        o = '0;
        for (int j = 0; j < 16; j++) begin
            o[127-8*j -: 8] = SBOX[s[127-8*ROW_PERM[j] -: 8]];
        end
        return o;
    endfunction

    function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
        logic [127:0] o;
        o = '0;
        for (int j = 0; j < 16; j++) begin
            o[127-8*ROW_PERM[j] -: 8] = INV_SBOX[s[127-8*j -: 8]];
        end
        return o;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0] a [4];
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) a[r] = s[127-8*(4*c+r) -: 8];
            for (int r = 0; r < 4; r++) begin
                o[127-8*(4*c+r) -: 8] = xt(a[r]) ^ xt(a[(r+1)%4]) ^ a[(r+1)%4]
                                      ^ a[(r+2)%4] ^ a[(r+3)%4];
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] inv_mix_cols(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                a[r]  = s[127-8*(4*c+r) -: 8];
                x2[r] = xt(a[r]);
                x4[r] = xt(x2[r]);
                x8[r] = xt(x4[r]);
            end
            for (int r = 0; r < 4; r++) begin
                o[127-8*(4*c+r) -: 8] =
                    (x8[r] ^ x4[r] ^ x2[r]) ^
                    (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4]) ^
                    (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4]) ^
                    (x8[(r+3)%4] ^ a[(r+3)%4]);
            end
        end
        return o;
    endfunction

endpackage

FILE: hdl/aes_block_cipher.sv
// AES-128/192/256 ECB cipher top level: round sequencer, state register and round-key RAM.
// Depends on aes_pkg, aes_ram, aes_key_exp and the defines header.
// Each input word goes through ST_LOAD (first round-key read) and ST_ROUND (Nr = 10, 12 or 14);
// the first word after reset or a configuration write first runs the key schedule in ST_EXPAND.
// One block at a time; one round per cycle until the last, which waits for a free output slot.
// Reset is synchronous, active low, and clears the key registers and the schedule flag.
`include "aes_block_cipher_defines.svh"
module aes_block_cipher import aes_pkg::*; #(
    parameter int ROUND_KEY_DEPTH = 60
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [127:0]  i_s_axis_tdata,   // block_in_low, block_in_high
    input  logic          i_s_axis_tuser,   // mode
    input  logic          i_s_axis_tlast,   // last_block
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [127:0]  o_m_axis_tdata,   // block_out_low, block_out_high
    output logic          o_m_axis_tlast,   // last_result
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data
);
    localparam int AW = $clog2(ROUND_KEY_DEPTH / 4);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXPAND = 4'b0010,
        ST_LOAD   = 4'b0100,
        ST_ROUND  = 4'b1000
    } t_state;

    t_state         r_state, n_state;
    logic [63:0]    r_key [4];
    logic [1:0]     r_key_size;
    logic           r_sched_ready;
    logic [127:0]   r_blk, n_blk;
    logic           r_mode, r_last;
    logic [3:0]     r_step, n_step;
    logic           r_out_valid;
    logic [127:0]   r_out_data;
    logic           r_out_last;

    t_kx_status     kx_status;
    logic           kx_start, kx_we;
    logic [AW-1:0]  kx_waddr;
    logic [127:0]   kx_wdata;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic [127:0]   rk;
    logic [3:0]     nr;
    logic           in_acc, cfg_acc, last_step, out_load;
    logic [127:0]   blk_in, round_out;

    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;
    assign blk_in  = {i_s_axis_tdata[63:0], i_s_axis_tdata[127:64]};

    always_comb begin
        case (r_key_size)
            KS_128:  nr = 4'd10;
            KS_192:  nr = 4'd12;
            default: nr = 4'd14;
        endcase
    end

    assign last_step = (r_step == nr);

    always_comb begin
        if (!r_mode) begin
            if (r_step == 4'd0)  round_out = r_blk ^ rk;
            else if (last_step)  round_out = sub_shift(r_blk) ^ rk;
            else                 round_out = mix_cols(sub_shift(r_blk)) ^ rk;
        end else begin
            if (r_step == 4'd0)  round_out = inv_sub_shift(r_blk ^ rk);
            else if (last_step)  round_out = r_blk ^ rk;
            else                 round_out = inv_sub_shift(inv_mix_cols(r_blk ^ rk));
        end
    end

    always_comb begin
        n_state  = r_state;
        n_blk    = r_blk;
        n_step   = r_step;
        kx_start = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = '0;
        out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_blk = blk_in;
                    if (r_sched_ready) begin
                        n_state = ST_LOAD;
                    end else begin
                        kx_start = 1'b1;
                        n_state  = ST_EXPAND;
                    end
                end
            end
            ST_EXPAND: begin
                if (kx_status.done) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                rd_en   = 1'b1;
                rd_addr = r_mode ? AW'(nr) : '0;
                n_step  = '0;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                if (!last_step) begin
                    rd_en   = 1'b1;
                    rd_addr = r_mode ? AW'(nr - r_step - 4'd1) : AW'(r_step + 4'd1);
                    n_blk   = round_out;
                    n_step  = r_step + 4'd1;
                end else if (!r_out_valid || i_m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_sched_ready <= 1'b0;
            r_out_valid   <= 1'b0;
            r_key_size    <= '0;
            for (int k = 0; k < 4; k++) r_key[k] <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_acc) begin
                r_sched_ready <= 1'b0;
                case (i_cfg_index)
                    REG_KEY0:  r_key[0]   <= i_cfg_data;
                    REG_KEY1:  r_key[1]   <= i_cfg_data;
                    REG_KEY2:  r_key[2]   <= i_cfg_data;
                    REG_KEY3:  r_key[3]   <= i_cfg_data;
                    REG_KSIZE: r_key_size <= i_cfg_data[1:0];
                    default: ;
                endcase
            end else if (kx_status.done) begin
                r_sched_ready <= 1'b1;
            end
            if (out_load)             r_out_valid <= 1'b1;
            else if (i_m_axis_tready) r_out_valid <= 1'b0;
        end
        r_blk  <= n_blk;
        r_step <= n_step;
        if (in_acc) begin
            r_mode <= i_s_axis_tuser;
            r_last <= i_s_axis_tlast;
        end
        if (out_load) begin
            r_out_data <= round_out;
            r_out_last <= r_last;
        end
    end

    aes_key_exp #(
        .ROUND_KEY_DEPTH(ROUND_KEY_DEPTH)
    ) u_key_exp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (kx_start),
        .i_key_size (r_key_size),
        .i_key      ({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .o_status   (kx_status),
        .o_we       (kx_we),
        .o_waddr    (kx_waddr),
        .o_wdata    (kx_wdata)
    );

    aes_ram #(
        .WIDTH(128),
        .DEPTH(ROUND_KEY_DEPTH / 4)
    ) u_rk_ram (
        .i_clk   (i_clk),
        .i_we    (kx_we),
        .i_waddr (kx_waddr),
        .i_wdata (kx_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rk)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_data[63:0], r_out_data[127:64]};
    assign o_m_axis_tlast  = r_out_last;

    `AES_ASSERT_IMPL(a_kx_only_expand, i_clk, i_rst_n, kx_status.busy, r_state == ST_EXPAND)
    `AES_ASSERT_NEXT(a_cfg_clears_ready, i_clk, i_rst_n, cfg_acc, !r_sched_ready)
    `AES_ASSERT_IMPL(a_step_bound, i_clk, i_rst_n, r_state == ST_ROUND, r_step <= nr)
    `AES_ASSERT_NEXT(a_out_from_round, i_clk, i_rst_n, out_load, r_out_valid && r_state == ST_IDLE)
endmodule

FILE: hdl/aes_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module aes_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 15
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/aes_key_exp.sv
// Key schedule sequencer: produces one round-key word per cycle and writes
// complete 128-bit round keys to the round-key RAM. Depends on aes_pkg.
module aes_key_exp import aes_pkg::*; #(
    parameter int ROUND_KEY_DEPTH = 60
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [1:0]                            i_key_size,
    input  logic [255:0]                          i_key,
    output t_kx_status                            o_status,
    output logic                                  o_we,
    output logic [$clog2(ROUND_KEY_DEPTH/4)-1:0]  o_waddr,
    output logic [127:0]                          o_wdata
);
    localparam int IW = $clog2(ROUND_KEY_DEPTH);
    localparam int AW = $clog2(ROUND_KEY_DEPTH / 4);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [IW-1:0] r_i, n_i;
    logic [2:0]    r_mod, n_mod;
    logic [7:0]    r_rcon, n_rcon;
    logic [31:0]   r_hist [8];
    logic [31:0]   r_buf [3];

    logic [2:0]    nk_m1;
    logic [IW-1:0] last_i;
    logic [31:0]   t, w, key_word;
    logic          is_key;

    always_comb begin
        case (i_key_size)
            KS_128:  begin nk_m1 = 3'd3; last_i = IW'(43); end
            KS_192:  begin nk_m1 = 3'd5; last_i = IW'(51); end
            default: begin nk_m1 = 3'd7; last_i = IW'(59); end
        endcase
        is_key   = ({{(IW-3){1'b0}}, 3'd0} + IW'(r_i) <= IW'(nk_m1));
        key_word = i_key[255 - 32*r_i[2:0] -: 32];
        t = r_hist[0];
        if (r_mod == 3'd0) begin
            t = sub_word({r_hist[0][23:0], r_hist[0][31:24]}) ^ {r_rcon, 24'h0};
        end else if (nk_m1 == 3'd7 && r_mod == 3'd4) begin
            t = sub_word(r_hist[0]);
        end
        w = is_key ? key_word : (r_hist[nk_m1] ^ t);

        n_busy = r_busy;
        n_done = 1'b0;
        n_i    = r_i;
        n_mod  = r_mod;
        n_rcon = r_rcon;
        if (i_start) begin
            n_busy = 1'b1;
            n_i    = '0;
            n_mod  = '0;
            n_rcon = 8'h01;
        end else if (r_busy) begin
            n_i   = r_i + 1'b1;
            n_mod = (r_mod == nk_m1) ? 3'd0 : r_mod + 1'b1;
            if (!is_key && r_mod == 3'd0) begin
                n_rcon = xt(r_rcon);
            end
            if (r_i == last_i) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_i    <= n_i;
        r_mod  <= n_mod;
        r_rcon <= n_rcon;
        if (r_busy && !i_start) begin
            r_hist[0] <= w;
            for (int k = 1; k < 8; k++) r_hist[k] <= r_hist[k-1];
            if (r_i[1:0] != 2'd3) r_buf[r_i[1:0]] <= w;
        end
    end

    assign o_we          = r_busy && !i_start && (r_i[1:0] == 2'd3);
    assign o_waddr       = AW'(r_i >> 2);
    assign o_wdata       = {r_buf[0], r_buf[1], r_buf[2], w};
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
endmodule

FILE: test/tb_aes_block_cipher.sv
`timescale 1ns / 100ps
// Self-checking testbench for aes_block_cipher: streams blocks under several keys and
// compares each result against an in-bench AES model. Depends on aes_pkg and the RTL.
module tb_aes_block_cipher;
    import aes_pkg::*;

    localparam logic [1:0] KS_256 = 2'd2;
    localparam logic [1:0] KS_SPARE = 2'd3;
    localparam logic [2:0] REG_UNUSED = 3'd5;
    localparam logic [2:0] REG_UNUSED_TOP = 3'd7;
    localparam int STALL_LIMIT = 6000;
    localparam int LONG_HOLD = 400;

    class aes_scoreboard;
        logic [63:0] key_reg [4];
        logic [1:0]  key_size_reg;
        logic [31:0] sched [60];
        bit          sched_valid;
        logic [7:0]  inv_tab [256];
        logic [128:0] pending_blocks [$];
        int          mismatches;

        function new();
            for (int i = 0; i < 256; i++) inv_tab[SBOX[i]] = i[7:0];
            for (int i = 0; i < 4; i++) key_reg[i] = '0;
            key_size_reg = KS_128;
            sched_valid = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] val);
            if (idx <= REG_KEY3) key_reg[idx[1:0]] = val;
            else if (idx == REG_KSIZE) key_size_reg = val[1:0];
            sched_valid = 0;
        endfunction

        function int key_words();
            return key_size_reg == KS_128 ? 4 : (key_size_reg == KS_192 ? 6 : 8);
        endfunction

        function logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
            logic [7:0] acc;
            acc = '0;
            for (int k = 0; k < 8; k++) begin
                if (b[k]) acc ^= a;
                a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            end
            return acc;
        endfunction

        function logic [31:0] subw(logic [31:0] w);
            return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
        endfunction

        function void expand_keys();
            int nk;
            logic [31:0] t;
            logic [8:0] rc;
            nk = key_words();
            rc = 9'h001;
            for (int i = 0; i < nk; i++)
                sched[i] = (i % 2) ? key_reg[i / 2][31:0] : key_reg[i / 2][63:32];
            for (int i = nk; i < 4 * (nk + 7); i++) begin
                t = sched[i - 1];
                if (i % nk == 0) begin
                    t = subw({t[23:0], t[31:24]}) ^ {rc[7:0], 24'h0};
                    rc = rc << 1;
                    if (rc[8]) rc ^= 9'h11b;
                end else if (nk > 6 && i % nk == 4) begin
                    t = subw(t);
                end
                sched[i] = sched[i - nk] ^ t;
            end
            sched_valid = 1;
        endfunction

        function void add_rk(ref logic [7:0] s [16], input int rnd);
            logic [31:0] w;
            for (int j = 0; j < 16; j++) begin
                w = sched[(4 * rnd + j / 4) % 60];
                s[j] ^= w[31 - 8 * (j % 4) -: 8];
            end
        endfunction

        function void sub_rows(ref logic [7:0] s [16], input bit inverse);
            logic [7:0] h [16];
            int p;
            h = s;
            for (int j = 0; j < 16; j++) begin
                p = (j + 4 * (j % 4)) % 16;
                if (inverse) s[p] = inv_tab[h[j]];
                else s[j] = SBOX[h[p]];
            end
        endfunction

        function void mix_state(ref logic [7:0] s [16], input bit inverse);
            logic [7:0] a [4];
            logic [7:0] m [4];
            if (inverse) m = '{8'd14, 8'd11, 8'd13, 8'd9};
            else m = '{8'd2, 8'd3, 8'd1, 8'd1};
            for (int c = 0; c < 16; c += 4) begin
                for (int r = 0; r < 4; r++) a[r] = s[c + r];
                for (int r = 0; r < 4; r++)
                    s[c + r] = gmul(a[r], m[0]) ^ gmul(a[(r + 1) % 4], m[1])
                             ^ gmul(a[(r + 2) % 4], m[2]) ^ gmul(a[(r + 3) % 4], m[3]);
            end
        endfunction

        function void note_input(logic decrypt, logic [63:0] hi, logic [63:0] lo, logic last);
            logic [7:0] s [16];
            logic [63:0] oh, ol;
            int nr;
            if (!sched_valid) expand_keys();
            nr = key_words() + 6;
            for (int j = 0; j < 8; j++) begin
                s[j] = hi[63 - 8 * j -: 8];
                s[8 + j] = lo[63 - 8 * j -: 8];
            end
            if (!decrypt) begin
                add_rk(s, 0);
                for (int r = 1; r < nr; r++) begin
                    sub_rows(s, 0);
                    mix_state(s, 0);
                    add_rk(s, r);
                end
                sub_rows(s, 0);
                add_rk(s, nr);
            end else begin
                add_rk(s, nr);
                sub_rows(s, 1);
                for (int r = nr - 1; r >= 1; r--) begin
                    add_rk(s, r);
                    mix_state(s, 1);
                    sub_rows(s, 1);
                end
                add_rk(s, 0);
            end
            for (int j = 0; j < 8; j++) begin
                oh[63 - 8 * j -: 8] = s[j];
                ol[63 - 8 * j -: 8] = s[8 + j];
            end
            pending_blocks.push_back({last, ol, oh});
        endfunction

        function void check_result(logic [127:0] data, logic last);
            logic [128:0] exp_word;
            if (pending_blocks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected word: data %h last %b", data, last);
                return;
            end
            exp_word = pending_blocks.pop_front();
            if (exp_word[63:0] !== data[63:0] || exp_word[127:64] !== data[127:64]
                    || exp_word[128] !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Word mismatch: expected high %h low %h last %b, got %h %h %b",
                             exp_word[63:0], exp_word[127:64], exp_word[128],
                             data[63:0], data[127:64], last);
            end
        endfunction

        function int outstanding();
            return pending_blocks.size();
        endfunction
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_valid = 0;
    logic [127:0] s_data = '0;
    logic         s_user = 0;
    logic         s_last = 0;
    logic         m_ready = 0;
    logic         cfg_valid = 0;
    logic [2:0]   cfg_index = '0;
    logic [63:0]  cfg_data = '0;
    wire          s_ready, m_valid, m_last, cfg_ready;
    wire [127:0]  m_data;

    aes_scoreboard sb = new();
    int  hold_cycles = 0;
    int  burst_left = 0;
    int  idle_cycles = 0;

    aes_block_cipher u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user), .i_s_axis_tlast(s_last),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tlast(m_last),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (m_valid && m_ready) sb.check_result(m_data, m_last);
    end

    // The receiver alternates between free-running, light and heavy stalling.
    int rx_phase = 0;
    int rx_style = 0;
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 0;
        end else begin
            if (rx_phase == 0) begin
                rx_style <= $urandom_range(0, 2);
                rx_phase <= $urandom_range(20, 80);
            end else begin
                rx_phase <= rx_phase - 1;
            end
            case (rx_style)
                0: begin
                    m_ready <= 1;
                end
                1: begin
                    m_ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    m_ready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("aes_block_cipher: mismatch");
            $finish;
        end
    end

    task automatic write_cfg(logic [2:0] idx, logic [63:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task automatic end_cfg();
        cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic send_block(logic decrypt, logic [63:0] hi, logic [63:0] lo, logic last);
        s_valid <= 1;
        s_user <= decrypt;
        s_data <= {lo, hi};
        s_last <= last;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        sb.note_input(decrypt, hi, lo, last);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        s_valid <= 0;
        @(posedge i_clk);
        while (sb.outstanding() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_key(logic [1:0] ks, logic [63:0] k0, logic [63:0] k1,
                           logic [63:0] k2, logic [63:0] k3);
        write_cfg(REG_KEY0, k0);
        write_cfg(REG_KEY1, k1);
        write_cfg(REG_KEY2, k2);
        write_cfg(REG_KEY3, k3);
        write_cfg(REG_KSIZE, {62'd0, ks});
        end_cfg();
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        logic [1:0] ks;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Zero key straight from reset, then the standard 128- and 192-bit test keys and an all-ones 256-bit key.
        send_block(1'b0, '0, '0, 1'b0);
        send_block(1'b1, '1, '1, 1'b1);
        drain();
        set_key(KS_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0);
        send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
        send_block(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b0);
        send_block(1'b0, '1, '0, 1'b0);
        drain();
        set_key(KS_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                64'h1011121314151617, '1);
        send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
        send_block(1'b1, '0, '1, 1'b1);
        drain();
        set_key(KS_256, '1, '1, '1, '1);
        send_block(1'b0, '1, '1, 1'b1);
        send_block(1'b1, '0, '0, 1'b0);
        drain();
        // The unused size code behaves as a 256-bit key.
        write_cfg(REG_KSIZE, {62'd0, KS_SPARE});
        end_cfg();
        send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
        drain();
        // A write to an unused index only forces a fresh key schedule.
        write_cfg(REG_UNUSED, '1);
        write_cfg(REG_UNUSED_TOP, '0);
        end_cfg();
        send_block(1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
        drain();

        for (int phase = 0; phase < 9; phase++) begin
            ks = 2'(phase % 4);
            if ($urandom_range(0, 1)) begin
                set_key(ks, rand_word(), rand_word(), rand_word(), rand_word());
            end else begin
                write_cfg(3'($urandom_range(0, 3)), rand_word());
                write_cfg(REG_KSIZE, {62'd0, ks});
                if ($urandom_range(0, 2) == 0)
                    write_cfg(3'($urandom_range(REG_UNUSED, REG_UNUSED_TOP)), rand_word());
                end_cfg();
            end
            if (phase == 3) hold_cycles = LONG_HOLD;
            for (int n = 0; n < 76; n++)
                send_block(1'($urandom_range(0, 1)), rand_word(), rand_word(),
                           1'($urandom_range(0, 1)));
            drain();
        end

        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("aes_block_cipher: match");
        end else begin
            $display("aes_block_cipher: mismatch");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hdl
hdl/aes_pkg.sv
hdl/aes_ram.sv
hdl/aes_key_exp.sv
hdl/aes_block_cipher.sv
test/tb_aes_block_cipher.sv
